>>> src/gkde_pkg.sv
// gkde_pkg: types, constants and tables shared by the kernel density estimator
// no dependencies; used by gkde_div, gaussian_kde_density and gkde_chk
package gkde_pkg;

    localparam int MAX_KERNELS  = 1024;
    localparam int MAX_DIMS     = 8;
    localparam int KI_W         = 10;
    localparam int DI_W         = 3;
    localparam int CENTRE_DEPTH = MAX_KERNELS * MAX_DIMS;
    localparam int CADDR_W      = KI_W + DI_W;

    localparam logic [1:0] CMD_LOAD_CENTRE = 2'd0;
    localparam logic [1:0] CMD_LOAD_BW     = 2'd1;
    localparam logic [1:0] CMD_QUERY       = 2'd2;

    localparam logic [1:0] CFG_DIMS    = 2'd0;
    localparam logic [1:0] CFG_KERNELS = 2'd1;
    localparam logic [1:0] CFG_MIN_BW  = 2'd2;

    localparam logic [3:0]  DIMS_RESET    = 4'd1;
    localparam logic [10:0] KERNELS_RESET = 11'd0;
    localparam logic [30:0] MIN_BW_RESET  = 31'd655;

    localparam logic [26:0] LOG2E_Q26   = 27'd96817625;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [31:0] SQRT2PI_Q30 = 32'd2691471616;
    localparam logic [28:0] T_CAP       = 29'h1000_0000;
    localparam logic [63:0] CONTRIB_CAP = 64'h0000_0800_0000_0000;
    localparam logic [3:0]  EXP_TERMS   = 4'd13;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [KI_W-1:0]    kernel_index;
        logic [DI_W-1:0]    dim_index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] density;
        logic        saturated;
        logic        no_kernels;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [63:0] rem_init;
        logic [63:0] den;
        logic [63:0] numer;
        logic [6:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_KTOP,
        S_BWCHK,
        S_DRD,
        S_DSUB,
        S_DSQ,
        S_DACC,
        S_DEN,
        S_TCHK,
        S_TDIV,
        S_U,
        S_Y,
        S_EMUL,
        S_EREC,
        S_ECOR,
        S_SMUL,
        S_NORMZ,
        S_QDIV,
        S_NORM,
        S_PROD,
        S_CONTRIB,
        S_MDIV,
        S_DONE
    } t_state;

    // floor(2^32 / n) for the series divisors
    function automatic logic [32:0] recip_q32(input logic [3:0] n);
        logic [32:0] r;
        unique case (n)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            4'd13:   r = 33'd330382099;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/gkde_div.sv
// gkde_div: shared restoring divider, one quotient bit per cycle
// depends on gkde_pkg for the request and response structs
module gkde_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gkde_pkg::t_div_req i_req,
    output gkde_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_rem;
    logic [63:0] r_den;
    logic [63:0] r_num;
    logic [63:0] r_quo;
    logic [6:0]  r_cnt;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_num[63]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_den <= i_req.den;
            r_num <= i_req.numer;
            r_quo <= '0;
            r_cnt <= i_req.steps;
        end else if (r_busy) begin
            r_rem <= ge ? diff[63:0] : trial[63:0];
            r_num <= {r_num[62:0], 1'b0};
            r_quo <= {r_quo[62:0], ge};
            r_cnt <= r_cnt - 7'd1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> src/gaussian_kde_density.sv
// loads and non-final query coordinates are only stored; the final query coordinate
// starts an evaluation: a kernel that fails the bandwidth check is skipped, and each
// kernel over the threshold runs the distance sum, the exponent division (skipped
// when the exponent is capped), the 13-term exp series and the normalize search,
// then the mean division runs through the shared divider if any kernel counted
// throughput: one query evaluation at a time; input stalls while it runs
// reset: synchronous active low, clears control and config; memories undefined
module gaussian_kde_density (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gkde_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gkde_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    logic [31:0] r_centre_mem [gkde_pkg::CENTRE_DEPTH];
    logic [31:0] r_bw_mem [gkde_pkg::MAX_KERNELS];
    logic [31:0] r_query [gkde_pkg::MAX_DIMS];
    logic [31:0] r_centre_rd;
    logic [31:0] r_bw_rd;

    logic [3:0]  r_dims;
    logic [10:0] r_nkern;
    logic [30:0] r_min_bw;

    gkde_pkg::t_state r_state, n_state;

    logic [10:0] r_kcnt;
    logic [3:0]  r_dj;
    logic [10:0] r_count;
    logic [63:0] r_sum;
    logic [30:0] r_s;
    logic [31:0] r_ad;
    logic [63:0] r_sq;
    logic [63:0] r_d2;
    logic [63:0] r_den;
    logic [28:0] r_t;
    logic [28:0] r_u;
    logic [12:0] r_k;
    logic [31:0] r_y;
    logic [32:0] r_term;
    logic [32:0] r_acc;
    logic [3:0]  r_n;
    logic [31:0] r_x;
    logic [31:0] r_q0;
    logic [62:0] r_dn;
    logic [5:0]  r_p;
    logic [31:0] r_q;
    logic [31:0] r_mm;
    logic signed [11:0] r_ee;
    logic [63:0] r_prod;
    logic signed [14:0] r_sh;
    gkde_pkg::t_out_item r_res;
    gkde_pkg::t_out_item r_out_data;
    logic r_out_valid;

    logic in_acc, in_eval, cfg_we, out_free;
    logic [10:0] nk;
    logic bw_ok, last_dim, t_cap;
    logic [gkde_pkg::CADDR_W-1:0] caddr_w, caddr_r;
    logic signed [32:0] diff;
    logic [61:0] ss;
    logic [55:0] u_prod;
    logic [47:0] y_prod;
    logic [64:0] x_prod;
    logic [64:0] q0_prod;
    logic [35:0] qn;
    logic [35:0] crem;
    logic [31:0] qq;
    logic [63:0] mm_prod;
    logic signed [11:0] er;
    logic [63:0] lim, shl, shr;
    logic signed [14:0] nsh;
    logic [63:0] contrib;
    gkde_pkg::t_div_req div_req;
    gkde_pkg::t_div_rsp div_rsp;

    gkde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // handshakes and decode
    always_comb begin
        in_acc   = i_in_valid && !o_in_stall;
        cfg_we   = i_cfg_valid && o_cfg_ready;
        out_free = !r_out_valid || !i_out_stall;
        in_eval  = in_acc && i_in_data.cmd == gkde_pkg::CMD_QUERY && r_dims != 4'd0
                   && r_dims <= 4'(gkde_pkg::MAX_DIMS)
                   && {1'b0, i_in_data.dim_index} == r_dims - 4'd1;
        nk       = (r_nkern > 11'(gkde_pkg::MAX_KERNELS)) ? 11'(gkde_pkg::MAX_KERNELS)
                                                         : r_nkern;
        caddr_w  = {i_in_data.kernel_index, i_in_data.dim_index};
        caddr_r  = {r_kcnt[gkde_pkg::KI_W-1:0], r_dj[gkde_pkg::DI_W-1:0]};
        bw_ok    = !r_bw_rd[31] && r_bw_rd[30:0] != 31'd0 && r_bw_rd[30:0] >= r_min_bw;
        last_dim = (r_dj + 4'd1) == r_dims;
        t_cap    = {12'd0, r_d2[63:12]} >= r_den;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.cmd == gkde_pkg::CMD_LOAD_CENTRE) begin
            r_centre_mem[caddr_w] <= i_in_data.value;
        end
        r_centre_rd <= r_centre_mem[caddr_r];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.cmd == gkde_pkg::CMD_LOAD_BW) begin
            r_bw_mem[i_in_data.kernel_index] <= i_in_data.value;
        end
        r_bw_rd <= r_bw_mem[r_kcnt[gkde_pkg::KI_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.cmd == gkde_pkg::CMD_QUERY) begin
            r_query[i_in_data.dim_index] <= i_in_data.value;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims   <= gkde_pkg::DIMS_RESET;
            r_nkern  <= gkde_pkg::KERNELS_RESET;
            r_min_bw <= gkde_pkg::MIN_BW_RESET;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                gkde_pkg::CFG_DIMS:    r_dims   <= i_cfg_data[3:0];
                gkde_pkg::CFG_KERNELS: r_nkern  <= i_cfg_data[10:0];
                gkde_pkg::CFG_MIN_BW:  r_min_bw <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gkde_pkg::S_IDLE:    if (in_eval) n_state = gkde_pkg::S_KTOP;
            gkde_pkg::S_KTOP: begin
                if (r_kcnt == nk) begin
                    n_state = (r_count == 11'd0) ? gkde_pkg::S_DONE : gkde_pkg::S_MDIV;
                end else begin
                    n_state = gkde_pkg::S_BWCHK;
                end
            end
            gkde_pkg::S_BWCHK:   n_state = bw_ok ? gkde_pkg::S_DRD : gkde_pkg::S_KTOP;
            gkde_pkg::S_DRD:     n_state = gkde_pkg::S_DSUB;
            gkde_pkg::S_DSUB:    n_state = gkde_pkg::S_DSQ;
            gkde_pkg::S_DSQ:     n_state = gkde_pkg::S_DACC;
            gkde_pkg::S_DACC:    n_state = last_dim ? gkde_pkg::S_DEN : gkde_pkg::S_DRD;
            gkde_pkg::S_DEN:     n_state = gkde_pkg::S_TCHK;
            gkde_pkg::S_TCHK:    n_state = t_cap ? gkde_pkg::S_U : gkde_pkg::S_TDIV;
            gkde_pkg::S_TDIV:    if (div_rsp.done) n_state = gkde_pkg::S_U;
            gkde_pkg::S_U:       n_state = gkde_pkg::S_Y;
            gkde_pkg::S_Y:       n_state = gkde_pkg::S_EMUL;
            gkde_pkg::S_EMUL:    n_state = gkde_pkg::S_EREC;
            gkde_pkg::S_EREC:    n_state = gkde_pkg::S_ECOR;
            gkde_pkg::S_ECOR: begin
                n_state = (r_n == gkde_pkg::EXP_TERMS) ? gkde_pkg::S_SMUL : gkde_pkg::S_EMUL;
            end
            gkde_pkg::S_SMUL:    n_state = gkde_pkg::S_NORMZ;
            gkde_pkg::S_NORMZ:   if (r_dn[62]) n_state = gkde_pkg::S_QDIV;
            gkde_pkg::S_QDIV:    if (div_rsp.done) n_state = gkde_pkg::S_NORM;
            gkde_pkg::S_NORM:    if (last_dim) n_state = gkde_pkg::S_PROD;
            gkde_pkg::S_PROD:    n_state = gkde_pkg::S_CONTRIB;
            gkde_pkg::S_CONTRIB: n_state = gkde_pkg::S_KTOP;
            gkde_pkg::S_MDIV:    if (div_rsp.done) n_state = gkde_pkg::S_DONE;
            gkde_pkg::S_DONE:    if (out_free) n_state = gkde_pkg::S_IDLE;
            default:             n_state = gkde_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall       = r_state != gkde_pkg::S_IDLE;
        o_cfg_ready      = 1'b1;
        div_req.start    = 1'b0;
        div_req.rem_init = '0;
        div_req.den      = '0;
        div_req.numer    = '0;
        div_req.steps    = '0;
        priority if (r_state == gkde_pkg::S_TCHK && !t_cap) begin
            div_req.start    = 1'b1;
            div_req.rem_init = {12'd0, r_d2[63:12]};
            div_req.den      = r_den;
            div_req.numer    = {r_d2[11:0], 52'd0};
            div_req.steps    = 7'd28;
        end else if (r_state == gkde_pkg::S_NORMZ && r_dn[62]) begin
            div_req.start    = 1'b1;
            div_req.rem_init = 64'h0000_0000_7FFF_FFFF;
            div_req.den      = {32'd0, r_dn[62:31]};
            div_req.numer    = {32'hFFFF_FFFF, 32'd0};
            div_req.steps    = 7'd32;
        end else if (r_state == gkde_pkg::S_KTOP && r_kcnt == nk && r_count != 11'd0) begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.den      = {53'd0, r_count};
            div_req.numer    = r_sum;
            div_req.steps    = 7'd64;
        end else begin
            div_req.start    = 1'b0;
        end
    end

    // datapath arithmetic
    always_comb begin
        diff    = $signed({r_query[r_dj[gkde_pkg::DI_W-1:0]][31],
                           r_query[r_dj[gkde_pkg::DI_W-1:0]]})
                  - $signed({r_centre_rd[31], r_centre_rd});
        ss      = 62'(r_s) * 62'(r_s);
        u_prod  = 56'(r_t) * 56'(gkde_pkg::LOG2E_Q26);
        y_prod  = 48'(r_u[15:0]) * 48'(gkde_pkg::LN2_Q32);
        x_prod  = 65'(r_term) * 65'(r_y);
        q0_prod = 65'(r_x) * 65'(gkde_pkg::recip_q32(r_n));
        qn      = 36'(r_q0) * 36'(r_n);
        crem    = {4'd0, r_x} - qn;
        qq      = (crem >= {32'd0, r_n}) ? r_q0 + 32'd1 : r_q0;
        mm_prod = 64'(r_mm) * 64'(r_q);
        er      = 12'sd14 - $signed({6'd0, r_p});
        lim     = gkde_pkg::CONTRIB_CAP >> r_sh[5:0];
        shl     = r_prod << r_sh[5:0];
        nsh     = -r_sh;
        shr     = r_prod >> nsh[5:0];
        if (!r_sh[14]) begin
            if (r_prod == 64'd0) begin
                contrib = '0;
            end else if (r_sh >= 15'sd44 || r_prod > lim) begin
                contrib = gkde_pkg::CONTRIB_CAP;
            end else begin
                contrib = shl;
            end
        end else if (nsh >= 15'sd64) begin
            contrib = '0;
        end else begin
            contrib = shr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gkde_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            gkde_pkg::S_IDLE: begin
                if (in_eval) begin
                    r_kcnt  <= '0;
                    r_count <= '0;
                    r_sum   <= '0;
                end
            end
            gkde_pkg::S_KTOP: begin
                if (r_kcnt == nk && r_count == 11'd0) begin
                    r_res <= '{density: 32'd0, saturated: 1'b0, no_kernels: 1'b1};
                end
            end
            gkde_pkg::S_BWCHK: begin
                if (bw_ok) begin
                    r_s     <= r_bw_rd[30:0];
                    r_count <= r_count + 11'd1;
                    r_dj    <= '0;
                    r_d2    <= '0;
                end else begin
                    r_kcnt <= r_kcnt + 11'd1;
                end
            end
            gkde_pkg::S_DSUB: r_ad <= diff[32] ? 32'(-diff) : 32'(diff);
            gkde_pkg::S_DSQ:  r_sq <= 64'(r_ad) * 64'(r_ad);
            gkde_pkg::S_DACC: begin
                r_d2 <= ({1'b0, r_d2} + {1'b0, r_sq} > 65'h0_FFFF_FFFF_FFFF_FFFF)
                        ? 64'hFFFF_FFFF_FFFF_FFFF : r_d2 + r_sq;
                r_dj <= r_dj + 4'd1;
            end
            gkde_pkg::S_DEN:  r_den <= {1'b0, ss, 1'b0};
            gkde_pkg::S_TCHK: if (t_cap) r_t <= gkde_pkg::T_CAP;
            gkde_pkg::S_TDIV: if (div_rsp.done) r_t <= div_rsp.quo[28:0];
            gkde_pkg::S_U:    r_u <= u_prod[54:26];
            gkde_pkg::S_Y: begin
                r_y    <= y_prod[47:16];
                r_k    <= r_u[28:16];
                r_term <= 33'h1_0000_0000;
                r_acc  <= 33'h1_0000_0000;
                r_n    <= 4'd1;
            end
            gkde_pkg::S_EMUL: r_x  <= x_prod[63:32];
            gkde_pkg::S_EREC: r_q0 <= q0_prod[63:32];
            gkde_pkg::S_ECOR: begin
                r_term <= {1'b0, qq};
                r_acc  <= r_n[0] ? r_acc - {1'b0, qq} : r_acc + {1'b0, qq};
                r_n    <= r_n + 4'd1;
            end
            gkde_pkg::S_SMUL: begin
                r_dn <= 63'(64'(gkde_pkg::SQRT2PI_Q30) * 64'(r_s));
                r_p  <= 6'd62;
            end
            gkde_pkg::S_NORMZ: begin
                if (!r_dn[62]) begin
                    r_dn <= {r_dn[61:0], 1'b0};
                    r_p  <= r_p - 6'd1;
                end
            end
            gkde_pkg::S_QDIV: begin
                if (div_rsp.done) begin
                    r_q  <= div_rsp.quo[31:0];
                    r_mm <= 32'h8000_0000;
                    r_ee <= -12'sd31;
                    r_dj <= '0;
                end
            end
            gkde_pkg::S_NORM: begin
                if (mm_prod[63]) begin
                    r_mm <= mm_prod[63:32];
                    r_ee <= r_ee + er + 12'sd32;
                end else begin
                    r_mm <= mm_prod[62:31];
                    r_ee <= r_ee + er + 12'sd31;
                end
                r_dj <= r_dj + 4'd1;
            end
            gkde_pkg::S_PROD: begin
                r_prod <= 64'(65'(r_mm) * 65'(r_acc));
                r_sh   <= 15'(r_ee) - 15'sd16 - $signed({2'd0, r_k});
            end
            gkde_pkg::S_CONTRIB: begin
                r_sum  <= r_sum + contrib;
                r_kcnt <= r_kcnt + 11'd1;
            end
            gkde_pkg::S_MDIV: begin
                if (div_rsp.done) begin
                    r_res.no_kernels <= 1'b0;
                    r_res.saturated  <= |div_rsp.quo[63:32];
                    r_res.density    <= (|div_rsp.quo[63:32]) ? 32'hFFFF_FFFF
                                                              : div_rsp.quo[31:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == gkde_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gkde_pkg::S_DONE && out_free) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> src/gkde_chk.sv
// gkde_chk: port-level checks for gaussian_kde_density, bound to the top level
// depends on gkde_pkg for the transaction structs
module gkde_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input gkde_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input gkde_pkg::t_out_item o_out_data,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [1:0]          i_cfg_index,
    input logic [31:0]         i_cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_no_kernels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_kernels |->
            o_out_data.density == 32'd0 && !o_out_data.saturated)
        else $error("empty result carries a density");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |-> o_out_data.density == 32'hFFFF_FFFF)
        else $error("saturated density not clamped");

    // evaluation only starts from an accepted query transaction
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && i_in_data.cmd == gkde_pkg::CMD_QUERY))
        else $error("busy without a query transaction");

endmodule

bind gaussian_kde_density gkde_chk u_gkde_chk (.*);

>>> tb/testbench.sv
// testbench for gaussian_kde_density: directed and random loads and queries,
// scoreboard class with a bit-exact density predictor; depends on gkde_pkg
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64;

    class density_board;
        logic [31:0] centre[gkde_pkg::CENTRE_DEPTH];
        logic [31:0] bw[gkde_pkg::MAX_KERNELS];
        logic [31:0] qbuf[gkde_pkg::MAX_DIMS];
        logic [3:0]  dims;
        logic [10:0] kern;
        logic [30:0] minbw;
        gkde_pkg::t_out_item want[$];
        int errors, mism, evals, empties, sats;

        function new();
            dims  = gkde_pkg::DIMS_RESET;
            kern  = gkde_pkg::KERNELS_RESET;
            minbw = gkde_pkg::MIN_BW_RESET;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                gkde_pkg::CFG_DIMS:    dims  = data[3:0];
                gkde_pkg::CFG_KERNELS: kern  = data[10:0];
                gkde_pkg::CFG_MIN_BW:  minbw = data[30:0];
                default: ;
            endcase
        endfunction

        function u64 ratio(u64 d2, u64 den);
            u64 q, r, fr;
            q  = d2 / den;
            r  = d2 % den;
            fr = 0;
            if (q >= 4096) return u64'(4096) << 16;
            for (int i = 0; i < 16; i++) begin
                r  = r << 1;
                fr = fr << 1;
                if (r >= den) begin
                    r  = r - den;
                    fr = fr | 1;
                end
            end
            return (q << 16) | fr;
        endfunction

        function u64 exp_neg(u64 y);
            u64 acc, term;
            acc  = u64'(1) << 32;
            term = u64'(1) << 32;
            for (int n = 1; n <= gkde_pkg::EXP_TERMS; n++) begin
                term = ((term * y) >> 32) / u64'(n);
                if (n % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
            return acc;
        endfunction

        function void norm(u64 s, int nd, output u64 m, output longint e);
            u64 d, q, mm, prod;
            longint p, er, ee;
            d  = u64'(gkde_pkg::SQRT2PI_Q30) * s;
            mm = u64'(1) << 31;
            p  = 31;
            ee = -31;
            while (p < 63 && (d >> (p + 1)) != 0) p++;
            q  = 64'h7FFF_FFFF_FFFF_FFFF / (d >> (p - 31));
            er = 16 - 2 - p;
            for (int i = 0; i < nd; i++) begin
                prod = mm * q;
                if (prod[63]) begin
                    mm = prod >> 32;
                    ee = ee + er + 32;
                end else begin
                    mm = prod >> 31;
                    ee = ee + er + 31;
                end
            end
            m = mm;
            e = ee;
        endfunction

        function u64 contribution(int k, u64 s);
            u64 d2, ad, sq, t, u, kk, f, y, ex, nm, prod;
            longint diff, ne, sh;
            d2 = 0;
            for (int i = 0; i < int'(dims); i++) begin
                diff = longint'($signed(qbuf[i]))
                       - longint'($signed(centre[k*gkde_pkg::MAX_DIMS+i]));
                ad   = (diff < 0) ? u64'(-diff) : u64'(diff);
                sq   = ad * ad;
                d2   = (d2 > ~u64'(0) - sq) ? ~u64'(0) : d2 + sq;
            end
            t  = ratio(d2, 2 * s * s);
            u  = (t * u64'(gkde_pkg::LOG2E_Q26)) >> 26;
            kk = u >> 16;
            f  = u & 64'hFFFF;
            y  = ((f << 16) * u64'(gkde_pkg::LN2_Q32)) >> 32;
            ex = exp_neg(y);
            norm(s, int'(dims), nm, ne);
            prod = nm * ex;
            sh   = ne - 32 - longint'(kk) + 16;
            if (sh >= 0) begin
                if (prod == 0) return 0;
                if (sh >= 64 || prod > (gkde_pkg::CONTRIB_CAP >> sh))
                    return gkde_pkg::CONTRIB_CAP;
                return prod << sh;
            end
            if (sh <= -64) return 0;
            return prod >> (-sh);
        endfunction

        function void note_input(gkde_pkg::t_in_item it);
            int nk, cnt;
            u64 sum, mean;
            longint s;
            gkde_pkg::t_out_item r;
            case (it.cmd)
                gkde_pkg::CMD_LOAD_CENTRE:
                    centre[it.kernel_index*gkde_pkg::MAX_DIMS + it.dim_index] = it.value;
                gkde_pkg::CMD_LOAD_BW: bw[it.kernel_index] = it.value;
                gkde_pkg::CMD_QUERY: begin
                    qbuf[it.dim_index] = it.value;
                    if (dims == 0 || dims > gkde_pkg::MAX_DIMS
                        || int'(it.dim_index) != int'(dims) - 1)
                        return;
                    nk  = (kern > gkde_pkg::MAX_KERNELS) ? gkde_pkg::MAX_KERNELS : int'(kern);
                    cnt = 0;
                    sum = 0;
                    for (int i = 0; i < nk; i++) begin
                        s = longint'($signed(bw[i]));
                        if (s <= 0 || s < longint'(minbw)) continue;
                        cnt++;
                        sum = sum + contribution(i, u64'(s));
                    end
                    r = '0;
                    if (cnt == 0) begin
                        r.no_kernels = 1'b1;
                        empties++;
                    end else begin
                        mean = sum / u64'(cnt);
                        if (mean > 64'hFFFF_FFFF) begin
                            r.density   = 32'hFFFF_FFFF;
                            r.saturated = 1'b1;
                            sats++;
                        end else begin
                            r.density = mean[31:0];
                        end
                    end
                    evals++;
                    want = {want, r};
                end
                default: ;
            endcase
        endfunction

        function void check_result(gkde_pkg::t_out_item got);
            gkde_pkg::t_out_item exp_r;
            if (want.size() == 0) begin
                errors++;
                mism++;
                if (mism <= 10) $display("unexpected result density=%h sat=%b none=%b",
                    got.density, got.saturated, got.no_kernels);
                return;
            end
            exp_r = want.pop_front();
            if (got !== exp_r) begin
                errors++;
                mism++;
                if (mism <= 10)
                    $display("mismatch: expected density=%h sat=%b none=%b, got %h %b %b",
                        exp_r.density, exp_r.saturated, exp_r.no_kernels,
                        got.density, got.saturated, got.no_kernels);
            end
        endfunction

        function void close();
            if (want.size() != 0) begin
                errors += want.size();
                $display("%0d expected results never arrived", want.size());
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    gkde_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    gkde_pkg::t_out_item o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [31:0]         i_cfg_data;

    gaussian_kde_density dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    density_board board = new();
    bit cen_set[gkde_pkg::CENTRE_DEPTH];
    bit bw_set[gkde_pkg::MAX_KERNELS];
    bit qry_set[gkde_pkg::MAX_DIMS];
    bit calm;
    int items_sent;
    int phases_run;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("gaussian_kde_density test failed");
        $finish;
    end

    function automatic int gap();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
        endcase
    endfunction

    function automatic logic [31:0] pick_bw();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(1, 1000);
            2: return -32'($urandom_range(0, 1000));
            default: return $urandom_range(32'h4000, 32'h40000);
        endcase
    endfunction

    task automatic drive(logic [1:0] c, logic [9:0] k, logic [2:0] d, logic [31:0] v);
        gkde_pkg::t_in_item it;
        int n;
        it.cmd          = c;
        it.kernel_index = k;
        it.dim_index    = d;
        it.value        = v;
        n = gap();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.note_input(it);
        items_sent++;
        case (c)
            gkde_pkg::CMD_LOAD_CENTRE: cen_set[k*gkde_pkg::MAX_DIMS + d] = 1'b1;
            gkde_pkg::CMD_LOAD_BW:     bw_set[k] = 1'b1;
            gkde_pkg::CMD_QUERY:       qry_set[d] = 1'b1;
            default: ;
        endcase
    endtask

    // fill every store entry the coming evaluation reads
    task automatic make_safe(logic [2:0] dfin);
        int nk;
        longint s;
        nk = (board.kern > gkde_pkg::MAX_KERNELS) ? gkde_pkg::MAX_KERNELS
                                                  : int'(board.kern);
        for (int i = 0; i < nk; i++) begin
            if (!bw_set[i])
                drive(gkde_pkg::CMD_LOAD_BW, 10'(i), 3'($urandom), (i < 16) ? pick_bw()
                      : -32'($urandom_range(0, 1000)));
            s = longint'($signed(board.bw[i]));
            if (s > 0 && s >= longint'(board.minbw))
                for (int d = 0; d < int'(board.dims); d++)
                    if (!cen_set[i*gkde_pkg::MAX_DIMS + d])
                        drive(gkde_pkg::CMD_LOAD_CENTRE, 10'(i), 3'(d), pick_coord());
        end
        for (int d = 0; d < int'(board.dims); d++)
            if (d != int'(dfin) && !qry_set[d])
                drive(gkde_pkg::CMD_QUERY, 10'($urandom), 3'(d), pick_coord());
    endtask

    task automatic put(logic [1:0] c, logic [9:0] k, logic [2:0] d, logic [31:0] v);
        if (c == gkde_pkg::CMD_QUERY && board.dims >= 1 && board.dims <= gkde_pkg::MAX_DIMS
            && int'(d) == int'(board.dims) - 1)
            make_safe(d);
        drive(c, k, d, v);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.want.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic setup(logic [3:0] nd, logic [10:0] nk, logic [30:0] mb);
        settle();
        write_reg(gkde_pkg::CFG_DIMS, 32'(nd));
        write_reg(gkde_pkg::CFG_KERNELS, 32'(nk));
        write_reg(gkde_pkg::CFG_MIN_BW, 32'(mb));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic query_all(logic [31:0] v);
        for (int d = 0; d < int'(board.dims); d++)
            put(gkde_pkg::CMD_QUERY, 10'($urandom), 3'(d), v);
    endtask

    task automatic random_phase(int p);
        logic [3:0]  nd;
        logic [10:0] nk;
        logic [30:0] mb;
        int start, nq, k;
        if (p == 3) nd = 4'd0;
        else if (p == 7) nd = 4'($urandom_range(9, 15));
        else if (p % 4 == 0) nd = 4'd8;
        else nd = 4'($urandom_range(1, 8));
        if (p == 2) nk = 11'd0;
        else if (p == 5) nk = 11'd12;
        else if (p == 9) nk = 11'd16;
        else nk = 11'($urandom_range(1, 12));
        if (p == 4) mb = 31'd0;
        else if (p == 5) mb = 31'h7FFF_FFFF;
        else if (p % 2 == 1) mb = gkde_pkg::MIN_BW_RESET;
        else mb = 31'($urandom_range(0, 32'h20000));
        setup(nd, nk, mb);
        calm = (p % 3 == 1);
        phases_run++;
        start = items_sent;
        while (items_sent - start < 38) begin
            case ($urandom_range(0, 19)) inside
                [0:8]: begin
                    nq = (nd >= 1 && nd <= gkde_pkg::MAX_DIMS) ? int'(nd)
                                                               : $urandom_range(1, 8);
                    for (int d = 0; d < nq; d++)
                        put(gkde_pkg::CMD_QUERY, 10'($urandom), 3'(d), pick_coord());
                end
                [9:15]: begin
                    k = $urandom_range(0, 15);
                    for (int d = 0; d < gkde_pkg::MAX_DIMS; d++)
                        if ($urandom_range(0, 3) != 0)
                            put(gkde_pkg::CMD_LOAD_CENTRE, 10'(k), 3'(d), pick_coord());
                    put(gkde_pkg::CMD_LOAD_BW, 10'(k), 3'($urandom), pick_bw());
                end
                default: put(2'($urandom_range(0, 3)), 10'($urandom), 3'($urandom), $urandom);
            endcase
        end
    endtask

    initial begin
        gkde_pkg::t_out_item got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = o_out_data;
                board.check_result(got);
            end
        end
    end

    initial begin
        int n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        calm = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: empty table, then an unused command
        put(gkde_pkg::CMD_QUERY, 10'd0, 3'd0, 32'd0);
        put(2'd3, 10'h3FF, 3'd7, 32'hFFFF_FFFF);
        setup(4'd1, 11'd1, gkde_pkg::MIN_BW_RESET);
        put(gkde_pkg::CMD_LOAD_CENTRE, 10'd0, 3'd0, 32'h7FFF_FFFF);
        put(gkde_pkg::CMD_LOAD_BW, 10'd0, 3'd0, 32'h0001_0000);
        put(gkde_pkg::CMD_QUERY, 10'd0, 3'd0, 32'h7FFF_FFFF);
        put(gkde_pkg::CMD_QUERY, 10'd0, 3'd0, 32'h8000_0000);
        // negative and zero bandwidth never count
        put(gkde_pkg::CMD_LOAD_BW, 10'd0, 3'd0, 32'h8000_0000);
        put(gkde_pkg::CMD_QUERY, 10'd0, 3'd0, 32'd0);
        setup(4'd1, 11'd1, 31'd0);
        put(gkde_pkg::CMD_LOAD_BW, 10'd0, 3'd0, 32'd0);
        put(gkde_pkg::CMD_QUERY, 10'd0, 3'd0, 32'd0);
        // tiny bandwidth, first over one dimension and then over eight
        put(gkde_pkg::CMD_LOAD_BW, 10'd0, 3'd0, 32'd1);
        put(gkde_pkg::CMD_QUERY, 10'd0, 3'd0, 32'h7FFF_FFFF);
        setup(4'd8, 11'd1, 31'd0);
        query_all(32'h7FFF_FFFF);
        setup(4'd0, 11'd1, 31'd0);
        put(gkde_pkg::CMD_QUERY, 10'd0, 3'd7, 32'h1234_5678);
        setup(4'd15, 11'd1, 31'd0);
        put(gkde_pkg::CMD_QUERY, 10'd0, 3'd7, 32'h0);

        for (int p = 0; p < 12; p++) random_phase(p);

        settle();
        repeat (300) @(posedge i_clk);
        board.close();
        $display("sent %0d items over %0d random phases: %0d densities, %0d empty, %0d clamped",
            items_sent, phases_run, board.evals, board.empties, board.sats);
        $display("%0d mismatches", board.mism);
        if (board.errors == 0) begin
            $display("gaussian_kde_density test passed");
        end else begin
            $display("gaussian_kde_density test failed");
        end
        $finish;
    end
endmodule
